FILE: sv/lav_pkg.sv
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared constants and vector types for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

	// Default number of fraction bits of the position inputs.
	localparam int POS_FRAC_BITS_DEF = 16;

	// Unit length in Q1.30.
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

	// Three 32-bit components, x in the lowest element.
	typedef logic [2:0][31:0] vec3_t;

	// Three 64-bit components, x in the lowest element.
	typedef logic [2:0][63:0] wvec3_t;

	// Three 31-bit magnitudes used by the short-vector test.
	typedef logic [2:0][30:0] mag3_t;

endpackage

FILE: sv/lav_unit3.sv
// ----------------------------------------------------------------------------
// Vector normalizer
// Pipelined normalization of a three-component vector to Q1.30, with a
// parallel short-vector test. One bit of square root and one bit of each
// quotient are resolved per stage.
// ----------------------------------------------------------------------------
module lav_unit3 #(
	parameter int Q      = 30,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  lav_pkg::wvec3_t     v,
	input  lav_pkg::mag3_t      t,
	input  logic                big,
	input  logic [SIDE_W-1:0]   side,
	output logic                out_valid,
	output lav_pkg::vec3_t      u,
	output logic                shrt,
	output logic [SIDE_W-1:0]   side_out
);
	import lav_pkg::*;

	// Squared-length threshold for a length of one millionth.
	localparam logic [63:0] THR = 64'((64'd1 << (2 * Q)) / 64'd1000000000000);

	// Stage map.
	localparam int ST_SUM   = 4;
	localparam int SQ_FIRST = 5;
	localparam int SQ_LAST  = 36;
	localparam int DV_INIT  = 37;
	localparam int DV_FIRST = 38;
	localparam int DV_LAST  = 68;
	localparam int NST      = 70;

	typedef struct packed {
		wvec3_t             v;
		mag3_t              t;
		logic               big;
		logic               shrt;
		logic [2:0]         neg;
		logic [2:0][61:0]   m;
		logic [2:0][61:0]   tsq;
		logic [5:0]         msb;
		mag3_t              ms;
		logic [2:0][61:0]   sq;
		logic [63:0]        srem;
		logic [31:0]        root;
		logic [2:0][62:0]   rem;
		mag3_t              quo;
		vec3_t              u;
		logic [SIDE_W-1:0]  side;
	} u3_t;

	u3_t              in_st;
	u3_t              pipe_q [NST];
	logic [NST-1:0]   vld_q;

	// Entry beat.
	always_comb begin
		in_st      = '0;
		in_st.v    = v;
		in_st.t    = t;
		in_st.big  = big;
		in_st.side = side;
	end

	for (genvar g = 0; g < NST; g++) begin : g_stage
		u3_t prv;
		u3_t nxt;

		if (g == 0) begin : g_first
			assign prv = in_st;
		end else begin : g_rest
			assign prv = pipe_q[g-1];
		end

		if (g == 0) begin : g_mag
			// Magnitudes, signs and squares for the short test.
			always_comb begin
				nxt = prv;
				for (int i = 0; i < 3; i++) begin
					nxt.neg[i] = prv.v[i][63];
					nxt.m[i]   = 62'(prv.v[i][63] ? (64'd0 - prv.v[i]) : prv.v[i]);
					nxt.tsq[i] = 62'(prv.t[i]) * 62'(prv.t[i]);
				end
			end
		end else if (g == 1) begin : g_lead
			// Leading one of the largest magnitude, and the short decision.
			logic [61:0] orv;
			logic [63:0] tsum;
			always_comb begin
				nxt  = prv;
				orv  = prv.m[0] | prv.m[1] | prv.m[2];
				tsum = 64'(prv.tsq[0]) + 64'(prv.tsq[1]) + 64'(prv.tsq[2]);
				nxt.msb = '0;
				for (int b = 0; b < 62; b++) begin
					if (orv[b]) begin
						nxt.msb = 6'(b);
					end
				end
				nxt.shrt = !prv.big && (tsum <= THR);
			end
		end else if (g == 2) begin : g_shift
			// Bring the largest magnitude into [2^30, 2^31).
			always_comb begin
				nxt = prv;
				for (int i = 0; i < 3; i++) begin
					if (prv.msb >= 6'd30) begin
						nxt.ms[i] = 31'(prv.m[i] >> (prv.msb - 6'd30));
					end else begin
						nxt.ms[i] = 31'(prv.m[i] << (6'd30 - prv.msb));
					end
				end
			end
		end else if (g == 3) begin : g_square
			always_comb begin
				nxt = prv;
				for (int i = 0; i < 3; i++) begin
					nxt.sq[i] = 62'(prv.ms[i]) * 62'(prv.ms[i]);
				end
			end
		end else if (g == ST_SUM) begin : g_sum
			always_comb begin
				nxt      = prv;
				nxt.srem = 64'(prv.sq[0]) + 64'(prv.sq[1]) + 64'(prv.sq[2]);
				nxt.root = '0;
			end
		end else if (g >= SQ_FIRST && g <= SQ_LAST) begin : g_sqrt
			// One root bit: try setting it against the running remainder.
			localparam int B = SQ_LAST - g;
			logic [65:0] trial;
			always_comb begin
				nxt   = prv;
				trial = (66'(prv.root) << (B + 1)) + (66'd1 << (2 * B));
				if (trial <= 66'(prv.srem)) begin
					nxt.srem = prv.srem - 64'(trial);
					nxt.root = prv.root | (32'd1 << B);
				end
			end
		end else if (g == DV_INIT) begin : g_dinit
			// Dividend with half the divisor added for rounding.
			always_comb begin
				nxt = prv;
				for (int i = 0; i < 3; i++) begin
					nxt.rem[i] = 63'({prv.ms[i], 30'd0}) + 63'(prv.root >> 1);
					nxt.quo[i] = '0;
				end
			end
		end else if (g >= DV_FIRST && g <= DV_LAST) begin : g_div
			// One quotient bit for each component.
			localparam int K = DV_LAST - g;
			logic [62:0] dvs;
			always_comb begin
				nxt = prv;
				dvs = 63'(prv.root) << K;
				for (int i = 0; i < 3; i++) begin
					if (prv.rem[i] >= dvs) begin
						nxt.rem[i] = prv.rem[i] - dvs;
						nxt.quo[i] = prv.quo[i] | (31'd1 << K);
					end
				end
			end
		end else begin : g_out
			// Clamp to unit length and restore the sign.
			logic [30:0] q;
			always_comb begin
				nxt = prv;
				q   = '0;
				for (int i = 0; i < 3; i++) begin
					q = (prv.quo[i] > 31'(ONE_Q30)) ? 31'(ONE_Q30) : prv.quo[i];
					nxt.u[i] = prv.neg[i] ? (32'd0 - 32'(q)) : 32'(q);
				end
			end
		end

		// Valid bit travels with the beat.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g] <= 1'b0;
			end else if (en) begin
				vld_q[g] <= (g == 0) ? in_valid : vld_q[(g == 0) ? 0 : g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_q[g] <= nxt;
			end
		end
	end

	assign out_valid = vld_q[NST-1];
	assign u         = pipe_q[NST-1].u;
	assign shrt      = pipe_q[NST-1].shrt;
	assign side_out  = pipe_q[NST-1].side;

endmodule

FILE: sv/lav_offset.sv
// ----------------------------------------------------------------------------
// Row translation term
// Four-stage pipeline computing the saturated negated dot product of one
// matrix row with the camera position.
// ----------------------------------------------------------------------------
module lav_offset (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  lav_pkg::vec3_t   row,
	input  lav_pkg::vec3_t   cam,
	output logic             out_valid,
	output lav_pkg::vec3_t   row_out,
	output logic [31:0]      off
);
	import lav_pkg::*;

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	vec3_t            row_s1, row_s2, row_s3, row_s4;
	wvec3_t           prod_s1;
	logic [63:0]      neg_sum_s2;
	logic [63:0]      mag_s3;
	logic             neg_s3;
	logic [31:0]      off_s4;

	logic [63:0]      rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Rounded magnitude of the negated sum.
	assign rnd = (mag_s3 + (64'd1 << 29)) >> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			// Products of row and camera components.
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= $signed(row[i]) * $signed(cam[i]);
			end
			row_s1 <= row;

			neg_sum_s2 <= 64'd0 - prod_s1[0] - prod_s1[1] - prod_s1[2];
			row_s2     <= row_s1;

			neg_s3 <= neg_sum_s2[63];
			mag_s3 <= neg_sum_s2[63] ? (64'd0 - neg_sum_s2) : neg_sum_s2;
			row_s3 <= row_s2;

			// Saturate to the signed 32-bit range.
			if (neg_s3) begin
				off_s4 <= (rnd > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - rnd[31:0]);
			end else begin
				off_s4 <= (rnd > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rnd[31:0];
			end
			row_s4 <= row_s3;
		end
	end

	assign out_valid = vld_s4;
	assign row_out   = row_s4;
	assign off       = off_s4;

endmodule

FILE: sv/look_at_view_matrix_top.sv
// Throughput: one beat per cycle; a stall on the output freezes every stage.
// The three normalizers (70 stages each, one square-root or quotient bit per
// stage) set the latency; every stage takes a new beat each cycle.
// Reset clears only the valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// Look-at view matrix
// Computes the right, up and forward rows with translation terms from a
// camera position and a target point.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top #(
	parameter int POS_FRAC_BITS = lav_pkg::POS_FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// camera_x, camera_y, camera_z, target_x, target_y, target_z
	input  logic [191:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// right_x, right_y, right_z, right_offset, up_x, up_y, up_z, up_offset,
	// forward_x, forward_y, forward_z, forward_offset
	output logic [383:0]  m_tdata
);
	import lav_pkg::*;

	localparam logic [32:0] POS_LIM = 33'd1 << POS_FRAC_BITS;

	logic en;

	// Input stage: direction and forward short-test magnitudes.
	vec3_t        cam_c, tgt_c;
	wvec3_t       vf_c;
	mag3_t        tf_c;
	logic         bigf_c;
	logic [32:0]  dif, dmag;

	logic         vld_s1;
	wvec3_t       vf_s1;
	mag3_t        tf_s1;
	logic         bigf_s1;
	vec3_t        cam_s1;

	// Forward normalizer outputs.
	logic         f_vld;
	vec3_t        f_raw;
	logic         f_sh;
	vec3_t        f_cam;

	// Right setup stage.
	vec3_t        f_c;
	logic         vld_s2;
	vec3_t        f_s2, cam_s2;
	wvec3_t       vr_s2;
	mag3_t        tr_s2;

	// Right normalizer outputs.
	logic         r_vld;
	vec3_t        r_raw;
	logic         r_sh;
	logic [191:0] r_side;

	// Up setup stages.
	vec3_t             r_c;
	logic              vld_s3, vld_s4, vld_s5;
	logic [3:0][63:0]  prod_s3;
	wvec3_t            x_s4, vu_s5;
	mag3_t             tu_c;
	logic              bigu_c;
	logic [63:0]       xmag, xrnd;
	mag3_t             tu_s5;
	logic              bigu_s5;
	vec3_t             f_s3, f_s4, f_s5;
	vec3_t             r_s3, r_s4, r_s5;
	vec3_t             cam_s3, cam_s4, cam_s5;

	// Up normalizer outputs.
	logic         u_vld;
	vec3_t        u_raw;
	logic         u_sh;
	logic [287:0] u_side;

	// Final rows.
	vec3_t        u_c;
	logic         vld_s6;
	vec3_t        f_s6, r_s6, u_s6, cam_s6;

	logic         ro_vld, uo_vld, fo_vld;
	vec3_t        r_out, u_out, f_out;
	logic [31:0]  r_off, u_off, f_off;

	// Whole pipeline advances unless a held output beat is not taken.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Difference and short-test inputs for the forward vector.
	always_comb begin
		bigf_c = 1'b0;
		dif    = '0;
		dmag   = '0;
		for (int i = 0; i < 3; i++) begin
			cam_c[i] = s_tdata[32*i +: 32];
			tgt_c[i] = s_tdata[96 + 32*i +: 32];
			dif      = {tgt_c[i][31], tgt_c[i]} - {cam_c[i][31], cam_c[i]};
			dmag     = dif[32] ? (33'd0 - dif) : dif;
			vf_c[i]  = {{31{dif[32]}}, dif};
			tf_c[i]  = dmag[30:0];
			bigf_c   = bigf_c | (dmag > POS_LIM);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vf_s1   <= vf_c;
			tf_s1   <= tf_c;
			bigf_s1 <= bigf_c;
			cam_s1  <= cam_c;
		end
	end

	lav_unit3 #(
		.Q      (POS_FRAC_BITS),
		.SIDE_W (96)
	) u_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.v         (vf_s1),
		.t         (tf_s1),
		.big       (bigf_s1),
		.side      (cam_s1),
		.out_valid (f_vld),
		.u         (f_raw),
		.shrt      (f_sh),
		.side_out  (f_cam)
	);

	// Forward with its +Z fallback; right is built from it.
	always_comb begin
		f_c = f_raw;
		if (f_sh) begin
			f_c    = '0;
			f_c[2] = ONE_Q30;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s2     <= f_c;
			cam_s2   <= f_cam;
			vr_s2[0] <= {{32{f_c[2][31]}}, f_c[2]};
			vr_s2[1] <= '0;
			vr_s2[2] <= 64'd0 - {{32{f_c[0][31]}}, f_c[0]};
			tr_s2[0] <= 31'(f_c[2][31] ? (32'd0 - f_c[2]) : f_c[2]);
			tr_s2[1] <= '0;
			tr_s2[2] <= 31'(f_c[0][31] ? (32'd0 - f_c[0]) : f_c[0]);
		end
	end

	lav_unit3 #(
		.Q      (30),
		.SIDE_W (192)
	) u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.v         (vr_s2),
		.t         (tr_s2),
		.big       (1'b0),
		.side      ({f_s2, cam_s2}),
		.out_valid (r_vld),
		.u         (r_raw),
		.shrt      (r_sh),
		.side_out  (r_side)
	);

	// Right with its +X fallback. Its y component is always zero, so the
	// cross product forward x right needs four products.
	always_comb begin
		r_c = r_raw;
		if (r_sh) begin
			r_c    = '0;
			r_c[0] = ONE_Q30;
		end
	end

	// Up short-test magnitudes: Q2.60 rounded to Q1.30.
	always_comb begin
		bigu_c = 1'b0;
		xmag   = '0;
		xrnd   = '0;
		for (int i = 0; i < 3; i++) begin
			xmag    = x_s4[i][63] ? (64'd0 - x_s4[i]) : x_s4[i];
			xrnd    = (xmag + (64'd1 << 29)) >> 30;
			tu_c[i] = xrnd[30:0];
			bigu_c  = bigu_c | (xrnd > 64'(ONE_Q30));
		end
	end

	// Forward sits in r_side[191:96] with x lowest.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3[0] <= $signed(r_side[159:128]) * $signed(r_c[2]);
			prod_s3[1] <= $signed(r_side[191:160]) * $signed(r_c[0]);
			prod_s3[2] <= $signed(r_side[127:96])  * $signed(r_c[2]);
			prod_s3[3] <= $signed(r_side[159:128]) * $signed(r_c[0]);
			f_s3       <= r_side[191:96];
			r_s3       <= r_c;
			cam_s3     <= r_side[95:0];

			x_s4[0] <= prod_s3[0];
			x_s4[1] <= prod_s3[1] - prod_s3[2];
			x_s4[2] <= 64'd0 - prod_s3[3];
			f_s4    <= f_s3;
			r_s4    <= r_s3;
			cam_s4  <= cam_s3;

			vu_s5   <= x_s4;
			tu_s5   <= tu_c;
			bigu_s5 <= bigu_c;
			f_s5    <= f_s4;
			r_s5    <= r_s4;
			cam_s5  <= cam_s4;
		end
	end

	lav_unit3 #(
		.Q      (30),
		.SIDE_W (288)
	) u_up (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.v         (vu_s5),
		.t         (tu_s5),
		.big       (bigu_s5),
		.side      ({r_s5, f_s5, cam_s5}),
		.out_valid (u_vld),
		.u         (u_raw),
		.shrt      (u_sh),
		.side_out  (u_side)
	);

	// Up with its +Y fallback.
	always_comb begin
		u_c = u_raw;
		if (u_sh) begin
			u_c    = '0;
			u_c[1] = ONE_Q30;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s6   <= u_c;
			r_s6   <= u_side[287:192];
			f_s6   <= u_side[191:96];
			cam_s6 <= u_side[95:0];
		end
	end

	// Valid bits of the stages kept at this level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= f_vld;
			vld_s3 <= r_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= u_vld;
		end
	end

	lav_offset u_roff (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.row       (r_s6),
		.cam       (cam_s6),
		.out_valid (ro_vld),
		.row_out   (r_out),
		.off       (r_off)
	);

	lav_offset u_uoff (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.row       (u_s6),
		.cam       (cam_s6),
		.out_valid (uo_vld),
		.row_out   (u_out),
		.off       (u_off)
	);

	lav_offset u_foff (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.row       (f_s6),
		.cam       (cam_s6),
		.out_valid (fo_vld),
		.row_out   (f_out),
		.off       (f_off)
	);

	assign m_tvalid = ro_vld & uo_vld & fo_vld;
	assign m_tdata  = {f_off, f_out, u_off, u_out, r_off, r_out};

`ifndef SYNTH
	// Right never has a y component.
	a_right_y_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[63:32] == 32'd0)
		else $error("right_y is not zero");

	// Forward is never the zero vector.
	a_fwd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[287:256] != 32'd0 || m_tdata[319:288] != 32'd0 ||
			m_tdata[351:320] != 32'd0))
		else $error("forward vector is zero");

	// Forward x stays within unit range.
	a_fwd_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[287:256]) <= $signed(32'h4000_0000) &&
			$signed(m_tdata[287:256]) >= $signed(32'hC000_0000)))
		else $error("forward_x out of range");

	// The three row pipelines stay in step.
	a_rows_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		ro_vld == uo_vld && uo_vld == fo_vld)
		else $error("offset pipelines out of step");
`endif

endmodule
